>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. Each use sits in a module that has
// clk and rst_n; checks are disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`endif

>>> sv/cds_pkg.sv
`default_nettype none

package cds_pkg;

  localparam int MODE_W   = 2;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int YEAR_W   = 14;
  localparam int STATUS_W = 2;

  localparam int YEAR_MAX_DEF = 9999;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHECK = 2'd0,
    MODE_NEXT  = 2'd1,
    MODE_PREV  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_31    = 5'd31;

  // 25 * INV25 == 1 mod 2**14; y is a multiple of 25 exactly when
  // y * INV25 mod 2**14 stays at or below floor((2**14 - 1) / 25).
  localparam logic [YEAR_W-1:0] INV25      = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIM  = YEAR_W'(((1 << YEAR_W) - 1) / 25);

  // 4/100/400 rule. Year 0 comes out leap.
  function automatic logic leap_year(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_LIM);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Days in a month; zero for a month number outside 1..12.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> sv/calendar_date_step.sv
// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+----------------------------
// input    | in_mode, in_month, in_day, in_year           | word taken when start & !busy
// result   | out_status, out_month, out_day, out_year,    | word shown one cycle with
//          | out_is_leap                                  | out_valid, never held off
//
// One word per cycle, sustained. A word passes through the input register,
// then the date logic (a 14-bit constant multiply for the leap test, small
// month-length compares) into the result register.
// busy is high only while rst_n is low; synchronous reset clears both valid
// flags. The receiver cannot stall, so nothing backs up.
`default_nettype none

`include "assert_macros.svh"

module calendar_date_step #(
  parameter int YEAR_MAX = cds_pkg::YEAR_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [cds_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [cds_pkg::MONTH_W-1:0]   in_month,
  input  wire logic [cds_pkg::DAY_W-1:0]     in_day,
  input  wire logic [cds_pkg::YEAR_W-1:0]    in_year,
  output logic                               out_valid,
  output logic [cds_pkg::STATUS_W-1:0]       out_status,
  output logic [cds_pkg::MONTH_W-1:0]        out_month,
  output logic [cds_pkg::DAY_W-1:0]          out_day,
  output logic [cds_pkg::YEAR_W-1:0]         out_year,
  output logic                               out_is_leap
);
  import cds_pkg::*;

  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);
  localparam logic [YEAR_W-1:0] YMIN = YEAR_W'(1);

  // input register
  logic               in_vld_r;
  logic [MODE_W-1:0]  mode_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [YEAR_W-1:0]  year_r;

  // result register
  logic                out_vld_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [MONTH_W-1:0]  month_o_r, month_nxt;
  logic [DAY_W-1:0]    day_o_r, day_nxt;
  logic [YEAR_W-1:0]   year_o_r, year_nxt;
  logic                leap_r, leap_nxt;

  logic               accept;
  logic [DAY_W-1:0]   mlen, prev_mlen;
  logic [MONTH_W-1:0] prev_month;
  logic               date_ok;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
    if (accept) begin
      mode_r  <= in_mode;
      month_r <= in_month;
      day_r   <= in_day;
      year_r  <= in_year;
    end
  end

  // --- date logic ---------------------------------------------------------
  assign leap_nxt   = leap_year(year_r);
  assign mlen       = month_len(month_r, leap_nxt);
  assign prev_month = month_r - 4'd1;
  assign prev_mlen  = month_len(prev_month, leap_nxt);

  // mlen is zero for a bad month, so day <= mlen also rejects those
  assign date_ok = (year_r >= YMIN) && (year_r <= YMAX) &&
                   (month_r >= MON_JAN) && (month_r <= MON_DEC) &&
                   (day_r != 5'd0) && (day_r <= mlen);

  always_comb begin
    status_nxt = ST_OK;
    month_nxt  = month_r;
    day_nxt    = day_r;
    year_nxt   = year_r;
    if (!date_ok) begin
      status_nxt = ST_BAD_DATE;
    end else begin
      unique case (mode_r)
        MODE_NEXT: begin
          if (day_r < mlen) begin
            day_nxt = day_r + 5'd1;
          end else if (month_r < MON_DEC) begin
            day_nxt   = DAY_FIRST;
            month_nxt = month_r + 4'd1;
          end else if (year_r < YMAX) begin
            day_nxt   = DAY_FIRST;
            month_nxt = MON_JAN;
            year_nxt  = year_r + 14'd1;
          end else begin
            status_nxt = ST_RANGE;   // past Dec 31 of the last year
          end
        end
        MODE_PREV: begin
          if (day_r > DAY_FIRST) begin
            day_nxt = day_r - 5'd1;
          end else if (month_r > MON_JAN) begin
            month_nxt = prev_month;
            day_nxt   = prev_mlen;
          end else if (year_r > YMIN) begin
            month_nxt = MON_DEC;
            day_nxt   = DAY_31;
            year_nxt  = year_r - 14'd1;
          end else begin
            status_nxt = ST_RANGE;   // before Jan 1 of year one
          end
        end
        default: begin
          // check only; unused mode code behaves the same
        end
      endcase
      if (status_nxt != ST_OK) begin
        month_nxt = month_r;
        day_nxt   = day_r;
        year_nxt  = year_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
    if (in_vld_r) begin
      status_r  <= status_nxt;
      month_o_r <= month_nxt;
      day_o_r   <= day_nxt;
      year_o_r  <= year_nxt;
      leap_r    <= leap_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_status  = status_r;
  assign out_month   = month_o_r;
  assign out_day     = day_o_r;
  assign out_year    = year_o_r;
  assign out_is_leap = leap_r;

  // --- checks -------------------------------------------------------------
  `ASSERT_CLK(a_lat_two, accept |-> ##2 out_valid)
  `ASSERT_CLK(a_no_orphan, out_valid |-> $past(accept, 2))
  `ASSERT_CLK(a_err_echo, (out_valid && out_status != ST_OK) |->
    (out_month == $past(in_month, 2) && out_day == $past(in_day, 2) &&
     out_year == $past(in_year, 2)))
  `ASSERT_NEVER(a_ok_bad_date, out_valid && out_status == ST_OK &&
    (out_month < MON_JAN || out_month > MON_DEC || out_day == 5'd0))

endmodule

`default_nettype wire

>>> verif/date_checker.sv
`timescale 1ns / 1ps

module date_checker #(
  parameter int YEAR_LIMIT = cds_pkg::YEAR_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [cds_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [cds_pkg::MONTH_W-1:0]   in_month,
  input  wire logic [cds_pkg::DAY_W-1:0]     in_day,
  input  wire logic [cds_pkg::YEAR_W-1:0]    in_year,
  input  wire logic                          out_valid,
  input  wire logic [cds_pkg::STATUS_W-1:0]  out_status,
  input  wire logic [cds_pkg::MONTH_W-1:0]   out_month,
  input  wire logic [cds_pkg::DAY_W-1:0]     out_day,
  input  wire logic [cds_pkg::YEAR_W-1:0]    out_year,
  input  wire logic                          out_is_leap,
  output int                                 errors,
  output int                                 pending
);
  import cds_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [YEAR_W-1:0]    year;
    logic                 leap;
  } date_word_t;

  date_word_t date_q[$];
  int         fail_cnt = 0;

  function automatic logic gregorian_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return gregorian_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Expected result word for one input word.
  function automatic date_word_t step_date(input logic [MODE_W-1:0]  mode,
                                           input logic [MONTH_W-1:0] month,
                                           input logic [DAY_W-1:0]   day,
                                           input logic [YEAR_W-1:0]  year);
    int unsigned m, d, y, nm, nd, ny;
    date_word_t  w;
    m  = month;
    d  = day;
    y  = year;
    nm = m;
    nd = d;
    ny = y;
    w.status = ST_OK;
    w.leap   = gregorian_leap(y);
    if (y < 1 || y > YEAR_LIMIT || d < 1 || d > days_in(m, y)) begin
      w.status = ST_BAD_DATE;
    end else if (mode == MODE_NEXT) begin
      if (d < days_in(m, y)) begin
        nd = d + 1;
      end else if (m < 12) begin
        nd = 1;
        nm = m + 1;
      end else if (y < YEAR_LIMIT) begin
        nd = 1;
        nm = 1;
        ny = y + 1;
      end else begin
        w.status = ST_RANGE;
      end
    end else if (mode == MODE_PREV) begin
      if (d > 1) begin
        nd = d - 1;
      end else if (m > 1) begin
        nm = m - 1;
        nd = days_in(nm, y);
      end else if (y > 1) begin
        nm = 12;
        nd = 31;
        ny = y - 1;
      end else begin
        w.status = ST_RANGE;
      end
    end
    // any nonzero status echoes the input date
    if (w.status != ST_OK) begin
      nm = m;
      nd = d;
      ny = y;
    end
    w.month = nm[MONTH_W-1:0];
    w.day   = nd[DAY_W-1:0];
    w.year  = ny[YEAR_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    date_word_t want;
    date_word_t seen;
    if (rst_n) begin
      if (out_valid) begin
        seen.status = status_t'(out_status);
        seen.month  = out_month;
        seen.day    = out_day;
        seen.year   = out_year;
        seen.leap   = out_is_leap;
        if (date_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result word with none expected: st=%0d %0d/%0d/%0d leap=%0b",
                     $time, seen.status, seen.month, seen.day, seen.year, seen.leap);
        end else begin
          want = date_q.pop_front();
          if (want.status !== seen.status || want.month !== seen.month ||
              want.day !== seen.day || want.year !== seen.year ||
              want.leap !== seen.leap) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch exp st=%0d %0d/%0d/%0d leap=%0b, got st=%0d %0d/%0d/%0d leap=%0b",
                       $time, want.status, want.month, want.day, want.year, want.leap,
                       seen.status, seen.month, seen.day, seen.year, seen.leap);
          end
        end
      end
      if (start && !busy)
        date_q.push_back(step_date(in_mode, in_month, in_day, in_year));
    end
    errors  <= fail_cnt;
    pending <= date_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

// Top level: drives date words into calendar_date_step and gives the verdict.
// All prediction and comparison lives in date_checker, which sits beside
// the block and watches both channels.
module testbench;
  import cds_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int DRAIN_CYCLES = 8;       // margin after pending reaches zero
  localparam int RANDOM_WORDS = 700;
  // 2-bit mode code with no enum member; block treats it as a check
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   in_mode;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic [YEAR_W-1:0]   in_year;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [YEAR_W-1:0]   out_year;
  logic                out_is_leap;

  int errors;
  int pending;
  int cycle_cnt = 0;
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  calendar_date_step #(
    .YEAR_MAX (YEAR_MAX_DEF)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_month    (in_month),
    .in_day      (in_day),
    .in_year     (in_year),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_month   (out_month),
    .out_day     (out_day),
    .out_year    (out_year),
    .out_is_leap (out_is_leap)
  );

  date_checker #(
    .YEAR_LIMIT (YEAR_MAX_DEF)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_mode     (in_mode),
    .in_month    (in_month),
    .in_day      (in_day),
    .in_year     (in_year),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_month   (out_month),
    .out_day     (out_day),
    .out_year    (out_year),
    .out_is_leap (out_is_leap),
    .errors      (errors),
    .pending     (pending)
  );

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one word and hold it until taken (start & !busy at an edge).
  // Words go out in bursts; when a burst runs out, start drops for a
  // random gap so idle cycles land on every phase of the pipeline.
  task automatic send_word(input logic [MODE_W-1:0] mode, input int month,
                           input int day, input int year);
    int gap;
    start    <= 1'b1;
    in_mode  <= mode;
    in_month <= month[MONTH_W-1:0];
    in_day   <= day[DAY_W-1:0];
    in_year  <= year[YEAR_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      start     <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int               yr;
    int               mo;
    int               dy;
    int               len;
    int               pick;
    logic             leap;
    logic [MODE_W-1:0] md;

    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_mode  <= MODE_CHECK;
    in_month <= '0;
    in_day   <= '0;
    in_year  <= '0;
    burst_left = $urandom_range(1, 40);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed words ---
    // range ends: first and last representable days
    send_word(MODE_CHECK, MON_JAN, DAY_FIRST, 1);
    send_word(MODE_PREV,  MON_JAN, DAY_FIRST, 1);            // steps below year 1
    send_word(MODE_CHECK, MON_DEC, DAY_31, YEAR_MAX_DEF);
    send_word(MODE_NEXT,  MON_DEC, DAY_31, YEAR_MAX_DEF);    // steps past top year
    // year rollover both ways
    send_word(MODE_NEXT,  MON_DEC, DAY_31, 2023);
    send_word(MODE_PREV,  MON_JAN, DAY_FIRST, 2024);
    // February in leap / common / century / 400-year
    send_word(MODE_NEXT,  MON_FEB, 28, 2024);
    send_word(MODE_NEXT,  MON_FEB, 29, 2024);
    send_word(MODE_NEXT,  MON_FEB, 28, 2023);
    send_word(MODE_CHECK, MON_FEB, 29, 2023);                // no leap day
    send_word(MODE_CHECK, MON_FEB, 29, 1900);                // century, not leap
    send_word(MODE_PREV,  3, DAY_FIRST, 1900);
    send_word(MODE_NEXT,  MON_FEB, 29, 2000);                // 400-year leap
    send_word(MODE_PREV,  3, DAY_FIRST, 2000);
    // 30-day month edges, month boundary either way
    send_word(MODE_NEXT,  4, 30, 2021);
    send_word(MODE_PREV,  5, DAY_FIRST, 2021);
    send_word(MODE_PREV,  MON_DEC, DAY_FIRST, 1999);
    send_word(MODE_NEXT,  MON_JAN, DAY_31, 1999);
    // bad fields: month 0 / 13 / 15, day 0, day 31 in a 30-day month
    send_word(MODE_NEXT,  0, DAY_FIRST, 2020);
    send_word(MODE_PREV,  13, 10, 2020);
    send_word(MODE_CHECK, 15, DAY_31, 16383);                // all-ones date fields
    send_word(MODE_NEXT,  6, 0, 2020);
    send_word(MODE_CHECK, 4, DAY_31, 2020);
    // year 0 (leap flag set yet invalid) and above the top year
    send_word(MODE_NEXT,  MON_JAN, DAY_FIRST, 0);
    send_word(MODE_PREV,  MON_JAN, DAY_FIRST, YEAR_MAX_DEF + 1);
    // spare mode code acts as a plain check
    send_word(MODE_SPARE, MON_FEB, 29, 2024);
    send_word(MODE_SPARE, 9, DAY_31, 2024);

    // --- random words ---
    // Mostly well-formed dates biased to month ends, leap-rule years and range ends,
    // a slice of near-miss dates, and some raw noise over the full field widths.
    repeat (RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_word(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                  $urandom_range(0, 31), $urandom_range(0, 16383));
      end else begin
        case ($urandom_range(0, 7))
          0:       yr = 400 * $urandom_range(1, 24);
          1:       yr = 100 * $urandom_range(1, 99);
          2:       yr = 4 * $urandom_range(1, 2499);
          3:       yr = $urandom_range(1, 3);
          4:       yr = $urandom_range(YEAR_MAX_DEF - 3, YEAR_MAX_DEF);
          default: yr = $urandom_range(1, YEAR_MAX_DEF);
        endcase
        mo   = $urandom_range(1, 12);
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        case (mo)
          2:           len = leap ? 29 : 28;
          4, 6, 9, 11: len = 30;
          default:     len = 31;
        endcase
        case ($urandom_range(0, 3))
          0:       dy = 1;
          1:       dy = len;
          2:       dy = len - 1;
          default: dy = $urandom_range(1, len);
        endcase
        // near-miss: one past month end (day 0 for 31-day months), or year out of range
        if (pick < 25) begin
          if ($urandom_range(0, 1))
            dy = (len < 31) ? len + 1 : 0;
          else
            yr = $urandom_range(0, 1) ? 0 : $urandom_range(YEAR_MAX_DEF + 1, 16383);
        end
        pick = $urandom_range(0, 9);
        md   = (pick == 0) ? MODE_CHECK :
               (pick == 1) ? MODE_SPARE :
               (pick < 6)  ? MODE_NEXT  : MODE_PREV;
        send_word(md, mo, dy, yr);
      end
    end

    // --- drain ---
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
